>>> rtl/wto_pkg.sv
// Shared types and constants for the wheel-tick odometry block.
// Used by the interfaces, controller, datapath and top level; depends on nothing.
package wto_pkg;

  // Configuration port widths and register indexes
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_LEFT_STEP_LENGTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_STEP_LENGTH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEFT_STEP_TURN    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_STEP_TURN   = 3'd3;

  localparam int LenW     = 24;
  localparam int TurnW    = 14;
  localparam int PosW     = 32;
  localparam int HeadingW = 16;

  // CORDIC vector registers (Q30) and start gain
  localparam int TrigW = 33;
  localparam logic signed [TrigW-1:0] GainQ30 = 33'sd652032874;

  // len * trig product and its rounding to Q16.16
  localparam int ProdW    = 58;
  localparam int RoundPos = 30;

  localparam int AtanIdxW = 5;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn32(input logic [AtanIdxW-1:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Controller to datapath commands
  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_STEP,
    OP_MUL_X,
    OP_MUL_Y,
    OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
  } dp_status_t;

endpackage

>>> rtl/wto_ifs.sv
// Valid/ready channel interfaces for ticks, poses and configuration writes.
// Depends on wto_pkg for payload widths.
interface wto_tick_if;
  logic valid;
  logic ready;
  logic wheel_side;
  logic channel_b_level;
  modport source (output valid, output wheel_side, output channel_b_level, input ready);
  modport sink   (input valid, input wheel_side, input channel_b_level, output ready);
endinterface

interface wto_pose_if;
  import wto_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [PosW-1:0]     x_out;
  logic signed [PosW-1:0]     y_out;
  logic [HeadingW-1:0]        heading_out;
  modport source (output valid, output x_out, output y_out, output heading_out, input ready);
  modport sink   (input valid, input x_out, input y_out, input heading_out, output ready);
endinterface

interface wto_cfg_if;
  import wto_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/wto_ctrl.sv
// Sequencer for one tick: accept, CORDIC iterations, two multiplies, commit.
// Depends on wto_pkg for the command and status structs.
module wto_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output wto_pkg::dp_cmd_t    cmd,
  input  wto_pkg::dp_status_t status
);
  import wto_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ITER,
    S_MUL_X,
    S_MUL_Y,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   commit;

  assign in_ready = (state == S_IDLE);
  assign commit   = (state == S_FINISH) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_START;
          state_next = S_ITER;
        end
      end
      S_ITER: begin
        cmd.op = OP_STEP;
        if (status.last_step) begin
          state_next = S_MUL_X;
        end
      end
      S_MUL_X: begin
        cmd.op     = OP_MUL_X;
        state_next = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.op     = OP_MUL_Y;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (commit) begin
          cmd.op     = OP_COMMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      priority if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end else begin
        out_valid <= out_valid;
      end
    end
  end

endmodule

>>> rtl/wto_dpath.sv
// Pose registers, iterative CORDIC, shared length multiplier and output register.
// Depends on wto_pkg for widths, the arctangent table and command structs.
module wto_dpath #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wto_pkg::dp_cmd_t                    cmd,
  output wto_pkg::dp_status_t                 status,
  input  logic                                wheel_side,
  input  logic                                channel_b_level,
  input  logic [wto_pkg::LenW-1:0]            left_len,
  input  logic [wto_pkg::LenW-1:0]            right_len,
  input  logic [wto_pkg::TurnW-1:0]           left_turn,
  input  logic [wto_pkg::TurnW-1:0]           right_turn,
  output logic signed [wto_pkg::PosW-1:0]     x_out,
  output logic signed [wto_pkg::PosW-1:0]     y_out,
  output logic [wto_pkg::HeadingW-1:0]        heading_out
);
  import wto_pkg::*;

  localparam int ZW  = ANGLE_BITS + 2;
  localparam int IW  = $clog2(CORDIC_STEPS);
  localparam int QS  = 32 - ANGLE_BITS;
  localparam int ShL = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int ShR = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam int HW  = ZW + 17;
  localparam logic [IW-1:0] LastStep = IW'(CORDIC_STEPS - 1);

  // item registers
  logic                is_right;
  logic                fwd;
  logic [LenW-1:0]     len;
  logic [TurnW-1:0]    turn;
  logic                flip;

  // CORDIC state
  logic signed [TrigW-1:0] cx;
  logic signed [TrigW-1:0] cy;
  logic signed [ZW-1:0]    z;
  logic [IW-1:0]           step_cnt;

  logic signed [ProdW-1:0] prod;
  logic [PosW-1:0]         dx;

  logic [PosW-1:0]     x_pos;
  logic [PosW-1:0]     y_pos;
  logic [HeadingW-1:0] heading;

  // start angle: fold into [-quarter, quarter] and scale to ANGLE_BITS
  logic signed [16:0]      h_s;
  logic signed [16:0]      h_adj;
  logic                    flip_now;
  logic signed [HW-1:0]    h_wide;
  logic signed [HW-1:0]    h_scaled;
  logic signed [ZW-1:0]    z_start;

  always_comb begin
    h_s      = $signed({heading[HeadingW-1], heading});
    h_adj    = h_s;
    flip_now = 1'b0;
    if (h_s > 17'sd16384) begin
      h_adj    = h_s - 17'sd32768;
      flip_now = 1'b1;
    end else if (h_s < -17'sd16384) begin
      h_adj    = h_s + 17'sd32768;
      flip_now = 1'b1;
    end
    h_wide   = HW'(h_adj);
    h_scaled = (h_wide <<< ShL) >>> ShR;
    z_start  = h_scaled[ZW-1:0];
  end

  // one micro-rotation per cycle
  logic [32:0]             atan_sum;
  logic [32:0]             atan_q;
  logic signed [ZW-1:0]    a_step;
  logic signed [TrigW-1:0] xs;
  logic signed [TrigW-1:0] ys;

  always_comb begin
    atan_sum = {1'b0, atan_turn32(AtanIdxW'(step_cnt))} + (33'd1 << (QS - 1));
    atan_q   = atan_sum >> QS;
    a_step   = $signed(atan_q[ZW-1:0]);
    xs       = cx >>> step_cnt;
    ys       = cy >>> step_cnt;
  end

  assign status.last_step = (step_cnt == LastStep);

  // shared multiplier and rounding to Q16.16
  logic signed [TrigW-1:0] trig_sel;
  logic signed [TrigW-1:0] trig;
  logic signed [ProdW-1:0] prod_next;
  logic signed [ProdW-1:0] rnd;

  always_comb begin
    trig_sel  = (cmd.op == OP_MUL_Y) ? cy : cx;
    trig      = flip ? -trig_sel : trig_sel;
    prod_next = ProdW'($signed({1'b0, len})) * ProdW'(trig);
    rnd       = (prod + (ProdW'(1) <<< (RoundPos - 1))) >>> RoundPos;
  end

  // pose update
  logic [PosW-1:0]     dy;
  logic [HeadingW-1:0] turn_ext;
  logic [PosW-1:0]     x_next;
  logic [PosW-1:0]     y_next;
  logic [HeadingW-1:0] heading_next;

  always_comb begin
    dy       = rnd[PosW-1:0];
    turn_ext = HeadingW'(turn);
    x_next   = fwd ? x_pos + dx : x_pos - dx;
    y_next   = fwd ? y_pos + dy : y_pos - dy;
    // counterclockwise for right forward and left backward
    heading_next = (fwd == is_right) ? heading + turn_ext : heading - turn_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos   <= '0;
      y_pos   <= '0;
      heading <= '0;
    end else if (cmd.op == OP_COMMIT) begin
      x_pos   <= x_next;
      y_pos   <= y_next;
      heading <= heading_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_START: begin
        is_right <= wheel_side;
        fwd      <= wheel_side ? !channel_b_level : channel_b_level;
        len      <= wheel_side ? right_len : left_len;
        turn     <= wheel_side ? right_turn : left_turn;
        flip     <= flip_now;
        cx       <= GainQ30;
        cy       <= '0;
        z        <= z_start;
        step_cnt <= '0;
      end
      OP_STEP: begin
        if (!z[ZW-1]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          z  <= z - a_step;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          z  <= z + a_step;
        end
        step_cnt <= step_cnt + IW'(1);
      end
      OP_MUL_X: begin
        prod <= prod_next;
      end
      OP_MUL_Y: begin
        dx   <= rnd[PosW-1:0];
        prod <= prod_next;
      end
      OP_COMMIT: begin
        x_out       <= $signed(x_next);
        y_out       <= $signed(y_next);
        heading_out <= heading_next;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/wheel_tick_odometry.sv
// Wheel-tick odometry top level: configuration registers, controller and datapath.
// Depends on wto_pkg, the channel interfaces, wto_ctrl and wto_dpath.
//
// Each encoder tick moves the pose (x, y) by the wheel's step length along the
// old heading and then turns the heading by the wheel's angle step; one pose
// request comes out per tick. From acceptance to the pose showing at the output,
// a tick passes through the shared CORDIC stage, which does one micro-rotation
// per cycle, then through the one length multiplier twice and a commit step that
// waits for the output register to be free. The block works on one tick at a
// time and takes the next one as soon as the pose is committed to the output
// register, even while that pose still waits to be taken. Configuration writes
// are always accepted; writes to unknown indexes are dropped.
module wheel_tick_odometry #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst,
  wto_tick_if.sink      tick,
  wto_pose_if.source    pose,
  wto_cfg_if.sink       cfg
);
  import wto_pkg::*;

  logic [LenW-1:0]  left_len;
  logic [LenW-1:0]  right_len;
  logic [TurnW-1:0] left_turn;
  logic [TurnW-1:0] right_turn;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_len   <= '0;
      right_len  <= '0;
      left_turn  <= '0;
      right_turn <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_LEFT_STEP_LENGTH:  left_len   <= cfg.data[LenW-1:0];
        CFG_RIGHT_STEP_LENGTH: right_len  <= cfg.data[LenW-1:0];
        CFG_LEFT_STEP_TURN:    left_turn  <= cfg.data[TurnW-1:0];
        CFG_RIGHT_STEP_TURN:   right_turn <= cfg.data[TurnW-1:0];
        default: begin
        end
      endcase
    end
  end

  wto_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (pose.valid),
    .out_ready (pose.ready),
    .cmd       (cmd),
    .status    (status)
  );

  wto_dpath #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .wheel_side      (tick.wheel_side),
    .channel_b_level (tick.channel_b_level),
    .left_len        (left_len),
    .right_len       (right_len),
    .left_turn       (left_turn),
    .right_turn      (right_turn),
    .x_out           (pose.x_out),
    .y_out           (pose.y_out),
    .heading_out     (pose.heading_out)
  );

endmodule

>>> rtl/wto_checker.sv
// Port-level checks for wheel_tick_odometry, attached by the bind below.
// Depends on wto_pkg for payload widths.
module wto_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          tick_valid,
  input logic                          tick_ready,
  input logic                          pose_valid,
  input logic                          pose_ready,
  input logic signed [wto_pkg::PosW-1:0] x_out,
  input logic signed [wto_pkg::PosW-1:0] y_out,
  input logic [wto_pkg::HeadingW-1:0]  heading_out
);
  import wto_pkg::*;

  logic tick_acc;
  assign tick_acc = tick_valid && tick_ready;

  // one tick in flight: no second tick is accepted right behind an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> !tick_ready)
    else $error("tick accepted while previous tick in flight");

  // no pose rises right behind an accepted tick
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    tick_acc |-> ##1 !$rose(pose_valid) ##1 !$rose(pose_valid))
    else $error("pose appeared too soon after a tick");

  // reset leaves no pose pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pose_valid)
    else $error("pose valid right after reset");

  // a stalled pose holds
  a_pose_hold: assert property (@(posedge clk) disable iff (rst)
    pose_valid && !pose_ready |=>
      pose_valid && $stable(x_out) && $stable(y_out) && $stable(heading_out))
    else $error("pose changed while stalled");

endmodule

bind wheel_tick_odometry wto_checker u_wto_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick.valid),
  .tick_ready  (tick.ready),
  .pose_valid  (pose.valid),
  .pose_ready  (pose.ready),
  .x_out       (pose.x_out),
  .y_out       (pose.y_out),
  .heading_out (pose.heading_out)
);
